// ===== design/cd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the circular deque.
// No dependencies; every other design file imports this package.
package cd_pkg;

   localparam int CD_DEPTH = 8;
   localparam int WORD_W   = 32;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef enum logic [1:0] {
      ACT_PUSH_FRONT = 2'd0,
      ACT_PUSH_REAR  = 2'd1,
      ACT_POP_FRONT  = 2'd2,
      ACT_POP_REAR   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // qualified command broadcast to every cell
   typedef struct packed {
      logic     push_front;
      logic     push_rear;
      logic     pop_front;
      logic     pop_rear;
      word_type push_value;
   } op_type;

endpackage

// ===== design/cd_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response of the deque.
// Depends on cd_pkg.
interface cd_req_if;
   import cd_pkg::*;

   logic       valid;
   logic       ready;
   action_type action;
   word_type   push_value;

   modport source (output valid, output action, output push_value, input ready);
   modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface cd_rsp_if;
   import cd_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   word_type   popped_value;
   logic       now_empty;
   logic       now_full;

   modport source (output valid, output status, output popped_value,
                   output now_empty, output now_full, input ready);
   modport sink   (input valid, input status, input popped_value,
                   input now_empty, input now_full, output ready);
endinterface

// ===== design/cd_cell.sv =====
`timescale 1ns / 1ps
// One storage cell of the deque row: a word and an occupied bit.
// Depends on cd_pkg; exchanges data with both neighbors every cycle.
module cd_cell (
   input  logic            clock,
   input  logic            reset,
   input  cd_pkg::op_type  op,
   input  cd_pkg::word_type left_data,
   input  logic            left_valid,
   input  cd_pkg::word_type right_data,
   input  logic            right_valid,
   output cd_pkg::word_type data_out,
   output logic            valid_out,
   output logic            valid_next,
   output cd_pkg::word_type rear_data
);
   import cd_pkg::*;

   word_type data_ff, data_in;
   logic     valid_ff, valid_in;
   logic     is_rear;

   assign is_rear = valid_ff && !right_valid;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (op.push_front) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (op.push_rear && !valid_ff && left_valid) begin
         data_in  = op.push_value;
         valid_in = 1'b1;
      end else if (op.pop_front) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (op.pop_rear && is_rear) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out   = data_ff;
   assign valid_out  = valid_ff;
   assign valid_next = valid_in;
   assign rear_data  = is_rear ? data_ff : '0;
endmodule

// ===== design/circular_deque.sv =====
`timescale 1ns / 1ps
// Double-ended queue of signed 32-bit words held in a row of DEPTH cells.
// Depends on cd_pkg, cd_req_if, cd_rsp_if and cd_cell.
//
// Usage:
//   req carries an action (push front, push rear, pop front, pop rear) and a
//   push value; rsp returns one response per request: status, popped value
//   (zero unless a pop succeeds), and the empty and full flags after it.
//   The front entry always sits in cell 0 and entries fill the row in order;
//   a front push or pop shifts every cell by one toward its neighbor.
// Latency: the response is valid the cycle after the request is taken.
// Throughput: one request per cycle while rsp is not held; each request is
//   a registered update of the cell row, and the response register frees in
//   the same cycle that the receiver takes its contents.
// Reset: synchronous; all cells are marked empty, no response is pending.
// Stall: while rsp is held, the response register keeps its contents and
//   req.ready stays low, so no request is taken or lost.
module circular_deque #(
   parameter int DEPTH = cd_pkg::CD_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   cd_req_if.sink   req_if,
   cd_rsp_if.source rsp_if
);
   import cd_pkg::*;

   word_type   cell_data [DEPTH];
   word_type   cell_rear [DEPTH];
   logic       cell_valid [DEPTH];
   logic       cell_valid_next [DEPTH];
   op_type     op;
   logic       accept, full, empty, is_push;
   word_type   rear_word;
   status_type status_in;
   word_type   popped_in;

   logic       rsp_valid_ff;
   status_type status_ff;
   word_type   popped_ff;
   logic       empty_ff, full_ff;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign full         = cell_valid[DEPTH-1];
   assign empty        = !cell_valid[0];
   assign is_push      = (req_if.action == ACT_PUSH_FRONT) ||
                         (req_if.action == ACT_PUSH_REAR);

   always_comb begin
      op.push_front = accept && (req_if.action == ACT_PUSH_FRONT) && !full;
      op.push_rear  = accept && (req_if.action == ACT_PUSH_REAR) && !full;
      op.pop_front  = accept && (req_if.action == ACT_POP_FRONT) && !empty;
      op.pop_rear   = accept && (req_if.action == ACT_POP_REAR) && !empty;
      op.push_value = req_if.push_value;
   end

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         word_type l_data, r_data;
         logic     l_valid, r_valid;
         if (i == 0) begin : g_first
            assign l_data  = req_if.push_value;
            assign l_valid = 1'b1;
         end else begin : g_mid_l
            assign l_data  = cell_data[i-1];
            assign l_valid = cell_valid[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign r_data  = '0;
            assign r_valid = 1'b0;
         end else begin : g_mid_r
            assign r_data  = cell_data[i+1];
            assign r_valid = cell_valid[i+1];
         end
         cd_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .op          (op),
            .left_data   (l_data),
            .left_valid  (l_valid),
            .right_data  (r_data),
            .right_valid (r_valid),
            .data_out    (cell_data[i]),
            .valid_out   (cell_valid[i]),
            .valid_next  (cell_valid_next[i]),
            .rear_data   (cell_rear[i])
         );
      end
   endgenerate

   always_comb begin
      rear_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rear_word = rear_word | cell_rear[i];
      end
   end

   always_comb begin
      status_in = ST_DONE;
      popped_in = '0;
      if (is_push && full) begin
         status_in = ST_FULL;
      end else if (!is_push && empty) begin
         status_in = ST_EMPTY;
      end else if (req_if.action == ACT_POP_FRONT) begin
         popped_in = cell_data[0];
      end else if (req_if.action == ACT_POP_REAR) begin
         popped_in = rear_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         popped_ff <= popped_in;
         empty_ff  <= !cell_valid_next[0];
         full_ff   <= cell_valid_next[DEPTH-1];
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = status_ff;
   assign rsp_if.popped_value = popped_ff;
   assign rsp_if.now_empty    = empty_ff;
   assign rsp_if.now_full     = full_ff;
endmodule
